// ===== rtl/topm_pkg.sv =====
// Shared constants, register index codes and item operation codes for the
// temporal outlier pixel mask. No dependencies.
package topm_pkg;

    localparam int MaxPixels   = 131072;
    localparam int MaxHistory  = 8;

    localparam int DepthW      = 16;
    localparam int ThreshW     = 16;
    localparam int HistLenW    = 4;
    localparam int FrameW      = 18;
    localparam int CfgIndexW   = 2;
    localparam int CfgDataW    = 18;

    localparam int MidDepth    = 2;
    localparam int OutDepth    = 4;

    localparam logic [ThreshW-1:0]  ThreshReset  = 16'd256;
    localparam logic [HistLenW-1:0] HistLenReset = 4'd3;
    localparam logic [FrameW-1:0]   FrameReset   = 18'd76800;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_DIFF_THRESHOLD = 2'd0,
        CFG_HISTORY_LEN    = 2'd1,
        CFG_FRAME_PIXELS   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_UPDATE = 2'd2
    } op_t;

endpackage

// ===== rtl/temporal_outlier_pixel_mask_core.sv =====
// Top level of the temporal outlier pixel mask: front classifier, item queue
// and history back end. Depends on topm_pkg, topm_fifo, topm_front, topm_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one depth pixel per transfer in
//   raster order: depth_now, depth_prev (unsigned Q8.8) and clear_history.
//   Output channel (out_valid/out_stall) carries depth_out and masked, one
//   result per input, in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata
//   while the block is idle: 0 diff_threshold, 1 history_len, 2 frame_pixels.
//   out_valid rises once a result reaches the output queue. Throughput is
//   one pixel per cycle unless stalled; the history read-modify-write (one
//   read and one write port) spans two back-end stages with write-data
//   forwarding so consecutive pixels at the same position stay correct.
//   After reset the history memory is swept to zero, one entry a cycle, over
//   all MAX_PIXELS entries (131072 by default); in_stall stays high during the
//   sweep while configuration writes are taken.
//   When the receiver stalls, results collect in a four-entry output queue
//   and the front keeps taking pixels until the internal queue fills, then
//   raises in_stall.
module temporal_outlier_pixel_mask_core #(
    parameter int MAX_PIXELS  = topm_pkg::MaxPixels,
    parameter int MAX_HISTORY = topm_pkg::MaxHistory
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [topm_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [topm_pkg::CfgDataW-1:0]    cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [topm_pkg::DepthW-1:0]      depth_now,
    input  logic [topm_pkg::DepthW-1:0]      depth_prev,
    input  logic                             clear_history,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [topm_pkg::DepthW-1:0]      depth_out,
    output logic                             masked
);

    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int QW = 2 + 1 + PW + MAX_HISTORY + topm_pkg::DepthW;

    logic                                    clearing;
    logic                                    q_push;
    logic [QW-1:0]                           q_wdata;
    logic                                    q_pop;
    logic [QW-1:0]                           q_rdata;
    logic                                    q_empty;
    logic                                    q_full;
    logic [$clog2(topm_pkg::MidDepth+1)-1:0] q_count;

    topm_front #(
        .MAX_PIXELS  (MAX_PIXELS),
        .MAX_HISTORY (MAX_HISTORY),
        .PW          (PW),
        .QW          (QW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .depth_now     (depth_now),
        .depth_prev    (depth_prev),
        .clear_history (clear_history),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    topm_fifo #(
        .WIDTH (QW),
        .DEPTH (topm_pkg::MidDepth)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_wdata),
        .pop   (q_pop),
        .dout  (q_rdata),
        .empty (q_empty),
        .full  (q_full),
        .count (q_count)
    );

    topm_back #(
        .MAX_PIXELS  (MAX_PIXELS),
        .MAX_HISTORY (MAX_HISTORY),
        .PW          (PW),
        .QW          (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty || (q_count == '0)),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .depth_out (depth_out),
        .masked    (masked)
    );

endmodule

// ===== rtl/topm_fifo.sv =====
// Small register queue with occupancy count, used between the front and back
// halves and at the result side. No dependencies.
module topm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign count   = count_reg;
    assign dout    = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/topm_front.sv =====
// Front half: configuration registers, input transfer, pixel position counter
// and outlier classification. Depends on topm_pkg.
module topm_front #(
    parameter int MAX_PIXELS  = topm_pkg::MaxPixels,
    parameter int MAX_HISTORY = topm_pkg::MaxHistory,
    parameter int PW          = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    parameter int QW          = 2 + 1 + PW + MAX_HISTORY + topm_pkg::DepthW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [topm_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [topm_pkg::CfgDataW-1:0]    cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [topm_pkg::DepthW-1:0]      depth_now,
    input  logic [topm_pkg::DepthW-1:0]      depth_prev,
    input  logic                             clear_history,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [QW-1:0]                    q_data
);

    localparam int PLW = $clog2(MAX_PIXELS+1);
    localparam int CW  = (PLW > topm_pkg::FrameW) ? PLW : topm_pkg::FrameW;
    localparam int HLW0 = $clog2(MAX_HISTORY+1);
    localparam int HLW = (HLW0 > topm_pkg::HistLenW) ? HLW0 : topm_pkg::HistLenW;

    typedef struct packed {
        topm_pkg::op_t                op;
        logic                         mark;
        logic [PW-1:0]                pos;
        logic [MAX_HISTORY-1:0]       win;
        logic [topm_pkg::DepthW-1:0]  depth;
    } item_t;

    logic [topm_pkg::ThreshW-1:0]   thresh_reg;
    logic [topm_pkg::ThreshW-1:0]   thresh_next;
    logic [topm_pkg::HistLenW-1:0]  hist_len_reg;
    logic [topm_pkg::HistLenW-1:0]  hist_len_next;
    logic [topm_pkg::FrameW-1:0]    frame_reg;
    logic [topm_pkg::FrameW-1:0]    frame_next;
    logic [PW-1:0]                  pos_reg;
    logic [PW-1:0]                  pos_next;

    logic                           accept;
    logic [CW-1:0]                  frame_ext;
    logic [CW-1:0]                  limit;
    logic [CW-1:0]                  pos_inc;
    logic [HLW-1:0]                 len_ext;
    logic [HLW-1:0]                 len_sat;
    logic [topm_pkg::DepthW-1:0]    diff;
    item_t                          item;

    assign in_stall = clearing || q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept;
    assign q_data   = item;

    always_comb
    begin
        thresh_next   = thresh_reg;
        hist_len_next = hist_len_reg;
        frame_next    = frame_reg;
        if (cfg_we)
        begin
            unique case (topm_pkg::cfg_index_t'(cfg_index))
                topm_pkg::CFG_DIFF_THRESHOLD: thresh_next   = cfg_wdata[topm_pkg::ThreshW-1:0];
                topm_pkg::CFG_HISTORY_LEN:    hist_len_next = cfg_wdata[topm_pkg::HistLenW-1:0];
                topm_pkg::CFG_FRAME_PIXELS:   frame_next    = cfg_wdata[topm_pkg::FrameW-1:0];
                default:                      thresh_next   = thresh_reg;
            endcase
        end
    end

    // saturate frame size into 1..MAX_PIXELS and advance position
    always_comb
    begin
        frame_ext = CW'(frame_reg);
        if (frame_ext == '0)
        begin
            limit = CW'(1);
        end
        else if (frame_ext > CW'(MAX_PIXELS))
        begin
            limit = CW'(MAX_PIXELS);
        end
        else
        begin
            limit = frame_ext;
        end
        pos_inc  = CW'(pos_reg) + CW'(1);
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (pos_inc >= limit) ? '0 : pos_inc[PW-1:0];
        end
    end

    // classify: clear, pass-through or history update with window mask
    always_comb
    begin
        len_ext = HLW'(hist_len_reg);
        len_sat = (len_ext > HLW'(MAX_HISTORY)) ? HLW'(MAX_HISTORY) : len_ext;
        diff    = (depth_now >= depth_prev) ? (depth_now - depth_prev)
                                            : (depth_prev - depth_now);
        item.mark  = (diff > thresh_reg);
        item.pos   = pos_reg;
        item.depth = depth_now;
        for (int i = 0; i < MAX_HISTORY; i++)
        begin
            item.win[i] = (HLW'(i) < len_sat);
        end
        if (clear_history)
        begin
            item.op = topm_pkg::OP_CLEAR;
        end
        else if (len_sat == '0)
        begin
            item.op = topm_pkg::OP_PASS;
        end
        else
        begin
            item.op = topm_pkg::OP_UPDATE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= topm_pkg::ThreshReset;
            hist_len_reg <= topm_pkg::HistLenReset;
            frame_reg    <= topm_pkg::FrameReset;
            pos_reg      <= '0;
        end
        else
        begin
            thresh_reg   <= thresh_next;
            hist_len_reg <= hist_len_next;
            frame_reg    <= frame_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ===== rtl/topm_back.sv =====
// Back half: mark history memory with post-reset clearing pass, history
// read-modify-write with forwarding, and result queue. Depends on topm_pkg,
// topm_fifo.
module topm_back #(
    parameter int MAX_PIXELS  = topm_pkg::MaxPixels,
    parameter int MAX_HISTORY = topm_pkg::MaxHistory,
    parameter int PW          = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    parameter int QW          = 2 + 1 + PW + MAX_HISTORY + topm_pkg::DepthW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  logic [QW-1:0]                    q_data,
    output logic                             q_pop,
    output logic                             clearing,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [topm_pkg::DepthW-1:0]      depth_out,
    output logic                             masked
);

    localparam int OW  = topm_pkg::DepthW + 1;
    localparam int OCW = $clog2(topm_pkg::OutDepth+1);
    localparam int SW  = $clog2(topm_pkg::OutDepth+2);

    typedef struct packed {
        topm_pkg::op_t                op;
        logic                         mark;
        logic [PW-1:0]                pos;
        logic [MAX_HISTORY-1:0]       win;
        logic [topm_pkg::DepthW-1:0]  depth;
    } item_t;

    logic [MAX_HISTORY-1:0]  hist_mem [MAX_PIXELS];

    logic                    clear_busy_reg;
    logic                    clear_busy_next;
    logic [PW-1:0]           clear_addr_reg;
    logic [PW-1:0]           clear_addr_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    item_t                   s1_item_reg;
    logic                    fwd_hit_reg;
    logic                    fwd_hit_next;
    logic [MAX_HISTORY-1:0]  fwd_data_reg;
    logic [MAX_HISTORY-1:0]  rd_data_reg;

    item_t                   q_item;
    logic [OCW-1:0]          out_count;
    logic                    out_full;
    logic                    out_empty;
    logic [OW-1:0]           out_data;
    logic [OW-1:0]           res_data;
    logic                    s1_writes;
    logic [MAX_HISTORY-1:0]  old_word;
    logic [MAX_HISTORY-1:0]  new_word;
    logic                    res_masked;
    logic                    mem_we;
    logic [PW-1:0]           mem_waddr;
    logic [MAX_HISTORY-1:0]  mem_wdata;

    assign q_item   = item_t'(q_data);
    assign clearing = clear_busy_reg;

    // pop only when the result queue has room for everything in flight
    assign q_pop = !q_empty && !clear_busy_reg
                   && ((SW'(out_count) + SW'(s1_valid_reg)) < SW'(topm_pkg::OutDepth));

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + PW'(1);
            if (clear_addr_reg == PW'(MAX_PIXELS-1))
            begin
                clear_busy_next = 1'b0;
                clear_addr_next = '0;
            end
        end
    end

    always_comb
    begin
        s1_writes = s1_valid_reg && (s1_item_reg.op != topm_pkg::OP_PASS);
        old_word  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        new_word  = '0;
        res_masked = 1'b0;
        unique case (s1_item_reg.op)
            topm_pkg::OP_UPDATE:
            begin
                new_word   = (old_word << 1) | MAX_HISTORY'(s1_item_reg.mark);
                res_masked = |(new_word & s1_item_reg.win);
            end
            topm_pkg::OP_CLEAR:
            begin
                new_word = '0;
            end
            default:
            begin
                new_word = old_word;
            end
        endcase
        res_data      = {(res_masked ? {topm_pkg::DepthW{1'b0}} : s1_item_reg.depth),
                         res_masked};
        s1_valid_next = q_pop;
        fwd_hit_next  = q_pop && s1_writes && (s1_item_reg.pos == q_item.pos);
    end

    always_comb
    begin
        if (clear_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_writes;
            mem_waddr = s1_item_reg.pos;
            mem_wdata = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_data_reg <= hist_mem[q_item.pos];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg  <= q_item;
            fwd_data_reg <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    topm_fifo #(
        .WIDTH (OW),
        .DEPTH (topm_pkg::OutDepth)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s1_valid_reg),
        .din   (res_data),
        .pop   (out_valid && !out_stall),
        .dout  (out_data),
        .empty (out_empty),
        .full  (out_full),
        .count (out_count)
    );

    assign out_valid = !out_empty && !(out_full && 1'b0);
    assign depth_out = out_data[OW-1:1];
    assign masked    = out_data[0];

endmodule
